/* src/brest_pkg.sv */
// Shared constants for the battery resistance estimator.
`default_nettype none
package brest_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_SENSE_EN = 2'd0;
  localparam logic [1:0] REG_TIME_CONST = 2'd1;
  localparam logic [1:0] REG_GAIN = 2'd2;

  localparam logic SENSE_EN_RESET = 1'b1;
  localparam logic [15:0] TIME_CONST_RESET = 16'd500;
  localparam logic [15:0] GAIN_RESET = 16'd6554;

  // Result status codes
  localparam logic [1:0] STATUS_UPDATED = 2'd0;
  localparam logic [1:0] STATUS_NO_CURRENT = 2'd1;
  localparam logic [1:0] STATUS_NO_DELTA = 2'd2;

  localparam logic [16:0] REST_MAX = 17'h1FFFF;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

endpackage
`default_nettype wire

/* src/brest_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module brest_div #(
  parameter int unsigned NUM_W = 56,
  parameter int unsigned DEN_W = 34
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign trial = shifted - {1'b0, den_r};
  assign fits = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= num;
        den_r <= den;
        cnt <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* src/brest_mul.sv */
// Shared shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module brest_mul #(
  parameter int unsigned A_W = 34,
  parameter int unsigned B_W = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic [A_W+B_W-1:0]      prod
);
  localparam int unsigned P_W = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   a_sh;
  logic [B_W-1:0]   b_sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod <= '0;
        a_sh <= P_W'(a);
        b_sh <= b;
        cnt <= CNT_W'(B_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (b_sh[0]) begin
          prod <= prod + a_sh;
        end
        a_sh <= {a_sh[P_W-2:0], 1'b0};
        b_sh <= {1'b0, b_sh[B_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* src/battery_resistance_estimator_top.sv */
// Battery internal resistance estimator: sequencer around a shared divider and multiplier.
//
// Input stream s_*: one battery sample per transaction, s_tdata holds from bit 0 up
// voltage_mv[15:0], current_ma[18:0] (signed), time_ms[31:0], zero padded to 72 bits.
// Output stream m_*: one result per sample, m_tdata holds resistance_q24[31:0] then
// resting_voltage_mv[16:0], zero padded to 56 bits; m_tuser carries the status.
// Config port: cfg_we writes cfg_data into register cfg_index (0 sensing enable,
// 1 filter time constant in ms, 2 blend gain Q0.16); write only while idle.
// Sequencing: a skipped sample passes from ST_CHECK straight to ST_OUT. An updated sample
// runs up to four divisions and six multiplications on the two shared serial units;
// s_tready is high only while the sequencer is idle, so one sample is in flight at a time.
// The result sits in an output register: the next sample is accepted while it waits,
// and a stalled receiver only holds the sequencer at its final step.
// Reset clears all estimator state to zero and loads the register defaults.
`default_nettype none
module battery_resistance_estimator_top #(
  parameter int unsigned FILTER_FRAC_BITS = brest_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // voltage_mv, current_ma, time_ms
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,  // resistance_q24, resting_voltage_mv
  output logic [1:0]       m_tuser,  // status
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import brest_pkg::*;

  localparam int unsigned FB = FILTER_FRAC_BITS;
  localparam int unsigned FI_W = 18 + FB;
  localparam int unsigned FV_W = 16 + FB;
  localparam int unsigned NUM_W = 40 + FB;
  localparam int unsigned DEN_W = 18 + FB;
  localparam int unsigned MA_W = (FI_W > 32) ? FI_W : 32;
  localparam int unsigned MB_W = (FB > 18) ? FB : 18;
  localparam int unsigned P_W = MA_W + MB_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_A, ST_GAIN, ST_W, ST_EST, ST_BLEND1, ST_BLEND2,
    ST_CAP, ST_FV, ST_FI, ST_REST, ST_OUT
  } state_t;

  state_t state;
  logic   go;
  logic   div_go;
  logic   mul_go;

  logic        sense_en;
  logic [15:0] time_const;
  logic [15:0] gain;

  logic [17:0]     peak;
  logic [FI_W-1:0] filt_i;
  logic [FV_W-1:0] filt_v;
  logic [15:0]     ref_v;
  logic [17:0]     ref_i;
  logic [31:0]     last_ms;
  logic [31:0]     res_est;
  logic [16:0]     rest_est;

  logic [15:0]     v_r;
  logic [17:0]     i_r;
  logic            i_nonpos;
  logic [31:0]     now_r;
  logic [1:0]      status;
  logic [15:0]     dt_r;
  logic [FB-1:0]   a_r;
  logic [FI_W-1:0] di_mag;
  logic            di_pos;
  logic [FV_W-1:0] dv_mag;
  logic            dv_pos;
  logic [16:0]     w_r;
  logic [31:0]     est_r;
  logic [31:0]     r_r;
  logic [48:0]     hold_r;

  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic             mul_done;
  logic [P_W-1:0]   mul_prod;

  logic [FI_W-1:0] i_q;
  logic [FV_W-1:0] v_q;
  logic [31:0]     dt;
  logic [31:0]     quo_sat;
  logic            cap_needed;
  logic [49:0]     blend_sum;
  logic [26:0]     rest_sum;
  logic [FI_W-1:0] fi_step;
  logic [FV_W-1:0] fv_step;

  assign i_q = {i_r, FB'(0)};
  assign v_q = {v_r, FB'(0)};
  assign dt = now_r - last_ms;
  assign quo_sat = (|div_quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign cap_needed = (ref_v > v_r) && (i_r > ref_i);
  assign blend_sum = {1'b0, hold_r} + {1'b0, mul_prod[48:0]};
  assign rest_sum = {11'd0, v_r} + {1'b0, mul_prod[24 +: 26]};
  assign fi_step = mul_prod[FB +: FI_W];
  assign fv_step = mul_prod[FB +: FV_W];
  assign s_tready = (state == ST_IDLE);

  // Start only the unit that the current step waits on
  assign div_go = go && ((state == ST_A) || (state == ST_W) || (state == ST_EST) ||
                         (state == ST_CAP));
  assign mul_go = go && !div_go;

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (state)
      ST_A: begin
        div_num = NUM_W'({dt_r, FB'(0)});
        div_den = DEN_W'({1'b0, dt_r} + {1'b0, time_const});
      end
      ST_W: begin
        div_num = NUM_W'(mul_prod[FB +: 34]);
        div_den = DEN_W'(peak);
      end
      ST_EST: begin
        div_num = {dv_mag, 24'd0};
        div_den = di_mag;
      end
      ST_CAP: begin
        div_num = NUM_W'({ref_v - v_r, 24'd0});
        div_den = DEN_W'(i_r - ref_i);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_GAIN: begin
        mul_a = MA_W'(di_mag);
        mul_b = MB_W'(gain);
      end
      ST_BLEND1: begin
        mul_a = MA_W'(r_r);
        mul_b = MB_W'(WEIGHT_ONE - w_r);
      end
      ST_BLEND2: begin
        mul_a = MA_W'(est_r);
        mul_b = MB_W'(w_r);
      end
      ST_FV: begin
        mul_a = MA_W'(dv_mag);
        mul_b = MB_W'(a_r);
      end
      ST_FI: begin
        mul_a = MA_W'(di_mag);
        mul_b = MB_W'(a_r);
      end
      ST_REST: begin
        mul_a = MA_W'(r_r);
        mul_b = MB_W'(i_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  brest_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  brest_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_en <= SENSE_EN_RESET;
      time_const <= TIME_CONST_RESET;
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSE_EN: sense_en <= cfg_data[0];
        REG_TIME_CONST: time_const <= cfg_data;
        REG_GAIN: gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go <= 1'b0;
      m_tvalid <= 1'b0;
      peak <= '0;
      filt_i <= '0;
      filt_v <= '0;
      ref_v <= '0;
      ref_i <= '0;
      last_ms <= '0;
      res_est <= '0;
      rest_est <= '0;
    end else begin
      go <= 1'b0;
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            v_r <= s_tdata[15:0];
            i_r <= s_tdata[33:16];
            i_nonpos <= s_tdata[34] || (s_tdata[33:16] == 18'd0);
            now_r <= s_tdata[66:35];
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!sense_en || i_nonpos) begin
            status <= STATUS_NO_CURRENT;
            state <= ST_OUT;
          end else begin
            if (i_r > peak) begin
              peak <= i_r;
            end
            if (i_q == filt_i) begin
              status <= STATUS_NO_DELTA;
              state <= ST_OUT;
            end else begin
              status <= STATUS_UPDATED;
              if (v_r > ref_v) begin
                ref_v <= v_r;
                ref_i <= i_r;
              end
              last_ms <= now_r;
              di_pos <= i_q > filt_i;
              di_mag <= (i_q > filt_i) ? i_q - filt_i : filt_i - i_q;
              dv_pos <= filt_v > v_q;
              dv_mag <= (filt_v > v_q) ? filt_v - v_q : v_q - filt_v;
              r_r <= res_est;
              dt_r <= dt[15:0];
              go <= 1'b1;
              if (dt >= {16'd0, time_const}) begin
                a_r <= FB'(1) << (FB - 1);
                state <= ST_GAIN;
              end else begin
                state <= ST_A;
              end
            end
          end
        end
        ST_A: begin
          if (div_done) begin
            a_r <= div_quo[FB-1:0];
            state <= ST_GAIN;
            go <= 1'b1;
          end
        end
        ST_GAIN: begin
          if (mul_done) begin
            state <= ST_W;
            go <= 1'b1;
          end
        end
        ST_W: begin
          if (div_done) begin
            if ((|div_quo[NUM_W-1:17]) || (div_quo[16:0] > WEIGHT_ONE)) begin
              w_r <= WEIGHT_ONE;
            end else begin
              w_r <= div_quo[16:0];
            end
            go <= 1'b1;
            if ((dv_mag != '0) && (dv_pos == di_pos)) begin
              state <= ST_EST;
            end else if (cap_needed) begin
              state <= ST_CAP;
            end else begin
              state <= ST_FV;
            end
          end
        end
        ST_EST: begin
          if (div_done) begin
            est_r <= quo_sat;
            state <= ST_BLEND1;
            go <= 1'b1;
          end
        end
        ST_BLEND1: begin
          if (mul_done) begin
            hold_r <= mul_prod[48:0];
            state <= ST_BLEND2;
            go <= 1'b1;
          end
        end
        ST_BLEND2: begin
          if (mul_done) begin
            r_r <= blend_sum[47:16];
            go <= 1'b1;
            state <= cap_needed ? ST_CAP : ST_FV;
          end
        end
        ST_CAP: begin
          if (div_done) begin
            if (quo_sat < r_r) begin
              r_r <= quo_sat;
            end
            state <= ST_FV;
            go <= 1'b1;
          end
        end
        ST_FV: begin
          if (mul_done) begin
            filt_v <= dv_pos ? filt_v - fv_step : filt_v + fv_step;
            res_est <= r_r;
            state <= ST_FI;
            go <= 1'b1;
          end
        end
        ST_FI: begin
          if (mul_done) begin
            filt_i <= di_pos ? filt_i + fi_step : filt_i - fi_step;
            state <= ST_REST;
            go <= 1'b1;
          end
        end
        ST_REST: begin
          if (mul_done) begin
            rest_est <= (|rest_sum[26:17]) ? REST_MAX : rest_sum[16:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {7'd0, (rest_est > {1'b0, v_r}) ? rest_est : {1'b0, v_r}, res_est};
            m_tuser <= status;
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/brest_checker.sv */
// Port-level checks for the battery resistance estimator, bound to the top level.
`default_nettype none
module brest_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import brest_pkg::*;

  // One sample in flight: take no new sample right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STATUS_UPDATED || m_tuser == STATUS_NO_CURRENT ||
                  m_tuser == STATUS_NO_DELTA))
    else $error("undefined status code");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result valid right after reset");
endmodule

bind battery_resistance_estimator_top brest_checker u_brest_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
